@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ASSERT_IMPLY(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// condition holds in the following cycle
`define ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/deq_pkg.sv @@
// types, constants and helper functions of the delay event queue
package deq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int TIME_BITS   = 32;

    localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int REC_BITS = IDX_BITS;

    localparam int ELAPSED_BITS = 31;
    localparam int OCC_BITS     = 5;
    localparam int ALU_BITS     = (TIME_BITS > ELAPSED_BITS) ? TIME_BITS : ELAPSED_BITS;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TIME   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [TAG_BITS-1:0]  tag_t;

    localparam time_t TIME_SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        event_tag;
        logic signed [31:0] event_delay;
        logic [30:0]        elapsed;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        out_tag;
        logic signed [31:0] out_delay;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } out_item_t;

    // sign-extend the incoming delay, then keep the time width
    function automatic time_t delay_to_time(input logic signed [31:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[TIME_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] time_to_delay(input time_t t);
        logic [63:0] w;
        w = 64'(signed'(t));
        return signed'(w[31:0]);
    endfunction

    function automatic tag_t tag_from_in(input logic [15:0] x);
        logic [63:0] w;
        w = 64'(x);
        return w[TAG_BITS-1:0];
    endfunction

    function automatic logic [15:0] tag_to_out(input tag_t t);
        logic [63:0] w;
        w = 64'(t);
        return w[15:0];
    endfunction

    // offset binary: unsigned order matches signed order
    function automatic time_t biased(input time_t t);
        return t ^ TIME_SIGN;
    endfunction

endpackage

@@ hw/rtl/deq_alu.sv @@
// shared subtractor used for delay compare and elapsed-time subtraction
module deq_alu (
    input  logic [deq_pkg::ALU_BITS-1:0] op_a,
    input  logic [deq_pkg::ALU_BITS-1:0] op_b,
    output logic [deq_pkg::ALU_BITS-1:0] diff,
    output logic                         borrow,
    output logic                         is_zero
);
    import deq_pkg::*;

    logic [ALU_BITS:0] wide;

    assign wide    = {1'b0, op_a} - {1'b0, op_b};
    assign diff    = wide[ALU_BITS-1:0];
    assign borrow  = wide[ALU_BITS];
    assign is_zero = (wide == '0);

endmodule

@@ hw/rtl/delay_event_queue.sv @@
// delay event queue: an accepted insert scans for the lowest free slot, a remove scans every slot
// and then commits, a time pass scans every slot; remove on empty, insert on full and unknown
// commands go straight to the result; the slot scan visits one slot per cycle through one subtractor
// one item at a time: the next item is taken the cycle after its result is loaded, so an item
// holds the input while the one before it is in flight or the output stays stalled
// synchronous active-low reset clears valid bits, count and handshake at once; no clearing pass
`include "assert_macros.svh"

module delay_event_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  deq_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output deq_pkg::out_item_t  m_item
);
    import deq_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INSERT = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]              state_reg;
    logic [1:0]              cmd_reg;
    tag_t                    tag_in_reg;
    time_t                   delay_in_reg;
    logic [ELAPSED_BITS-1:0] elapsed_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [QUEUE_DEPTH-1:0]  valid_reg;
    logic [REC_BITS-1:0]     rec_reg [QUEUE_DEPTH];
    logic [CNT_BITS-1:0]     held_reg;

    logic                    stg_live_reg;
    logic [IDX_BITS-1:0]     stg_idx_reg;
    tag_t                    rd_tag_reg;
    time_t                   rd_delay_reg;

    logic                    have_best_reg;
    logic [IDX_BITS-1:0]     best_idx_reg;
    logic [REC_BITS-1:0]     best_rec_reg;
    tag_t                    best_tag_reg;
    time_t                   best_delay_reg;

    tag_t                    res_tag_reg;
    time_t                   res_delay_reg;
    logic [1:0]              res_status_reg;
    logic                    m_valid_reg;
    out_item_t               m_item_reg;

    tag_t                    tag_mem   [QUEUE_DEPTH];
    time_t                   delay_mem [QUEUE_DEPTH];

    logic [IDX_BITS-1:0]     cnt_idx;
    logic                    scan_issue;
    logic                    ins_hit;
    logic                    time_wr;
    logic                    delay_we;
    logic [IDX_BITS-1:0]     delay_wr_idx;
    time_t                   delay_wdata;
    logic                    rec_dec;

    logic [ALU_BITS-1:0]     alu_a;
    logic [ALU_BITS-1:0]     alu_b;
    logic [ALU_BITS-1:0]     alu_diff;
    logic                    alu_borrow;
    logic                    alu_zero;
    time_t                   sat_time;
    logic                    better;

    assign cnt_idx    = cnt_reg[IDX_BITS-1:0];
    assign scan_issue = (state_reg == ST_SCAN) && (cnt_reg < CNT_BITS'(QUEUE_DEPTH));
    assign ins_hit    = (state_reg == ST_INSERT) && !valid_reg[cnt_idx];
    assign time_wr    = (state_reg == ST_SCAN) && (cmd_reg == CMD_TIME) && stg_live_reg;
    assign delay_we   = ins_hit || time_wr;
    assign delay_wr_idx = ins_hit ? cnt_idx : stg_idx_reg;
    assign delay_wdata  = ins_hit ? delay_in_reg : sat_time;
    assign rec_dec    = (state_reg == ST_COMMIT);

    // one subtractor: compare against best on remove, subtract elapsed on time passes
    assign alu_a = ALU_BITS'(biased(rd_delay_reg));
    assign alu_b = (cmd_reg == CMD_TIME) ? ALU_BITS'(elapsed_reg)
                                         : ALU_BITS'(biased(best_delay_reg));

    deq_alu u_alu (
        .op_a    (alu_a),
        .op_b    (alu_b),
        .diff    (alu_diff),
        .borrow  (alu_borrow),
        .is_zero (alu_zero)
    );

    // saturate at the most negative delay
    assign sat_time = (alu_borrow ? '0 : alu_diff[TIME_BITS-1:0]) ^ TIME_SIGN;

    // ties go to the newest entry (lowest recency rank)
    assign better = !have_best_reg || alu_borrow ||
                    (alu_zero && (rec_reg[stg_idx_reg] < best_rec_reg));

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // slot storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (ins_hit) begin
            tag_mem[cnt_idx] <= tag_in_reg;
        end
        if (delay_we) begin
            delay_mem[delay_wr_idx] <= delay_wdata;
        end
        if (scan_issue) begin
            rd_tag_reg   <= tag_mem[cnt_idx];
            rd_delay_reg <= delay_mem[cnt_idx];
        end
    end

    // recency ranks, 0 is newest
    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (ins_hit && valid_reg[i]) begin
                rec_reg[i] <= rec_reg[i] + REC_BITS'(1);
            end else if (rec_dec && valid_reg[i] && (rec_reg[i] > best_rec_reg)) begin
                rec_reg[i] <= rec_reg[i] - REC_BITS'(1);
            end
        end
        if (ins_hit) begin
            rec_reg[cnt_idx] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            held_reg      <= '0;
            cnt_reg       <= '0;
            stg_live_reg  <= 1'b0;
            have_best_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // a finishing item reloads the output itself
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end

            stg_live_reg <= scan_issue && valid_reg[cnt_idx];
            stg_idx_reg  <= cnt_idx;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg        <= s_item.command;
                        tag_in_reg     <= tag_from_in(s_item.event_tag);
                        delay_in_reg   <= delay_to_time(s_item.event_delay);
                        elapsed_reg    <= s_item.elapsed;
                        cnt_reg        <= '0;
                        have_best_reg  <= 1'b0;
                        res_tag_reg    <= '0;
                        res_delay_reg  <= '0;
                        res_status_reg <= STATUS_OK;
                        case (s_item.command)
                            CMD_INSERT: begin
                                if (held_reg == CNT_BITS'(QUEUE_DEPTH)) begin
                                    res_status_reg <= STATUS_FULL;
                                    state_reg      <= ST_FINISH;
                                end else begin
                                    state_reg <= ST_INSERT;
                                end
                            end
                            CMD_REMOVE: begin
                                if (held_reg == '0) begin
                                    res_status_reg <= STATUS_EMPTY;
                                    state_reg      <= ST_FINISH;
                                end else begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            CMD_TIME: begin
                                state_reg <= ST_SCAN;
                            end
                            default: begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_INSERT: begin
                    // lowest free slot wins
                    if (ins_hit) begin
                        valid_reg[cnt_idx] <= 1'b1;
                        held_reg           <= held_reg + CNT_BITS'(1);
                        state_reg          <= ST_FINISH;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_BITS'(1);
                    end
                end
                ST_SCAN: begin
                    if (stg_live_reg && (cmd_reg == CMD_REMOVE) && better) begin
                        have_best_reg  <= 1'b1;
                        best_idx_reg   <= stg_idx_reg;
                        best_rec_reg   <= rec_reg[stg_idx_reg];
                        best_tag_reg   <= rd_tag_reg;
                        best_delay_reg <= rd_delay_reg;
                    end
                    // the read stage lags the counter by one slot
                    if (cnt_reg == CNT_BITS'(QUEUE_DEPTH)) begin
                        state_reg <= (cmd_reg == CMD_REMOVE) ? ST_COMMIT : ST_FINISH;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_BITS'(1);
                    end
                end
                ST_COMMIT: begin
                    valid_reg[best_idx_reg] <= 1'b0;
                    held_reg                <= held_reg - CNT_BITS'(1);
                    res_tag_reg             <= best_tag_reg;
                    res_delay_reg           <= best_delay_reg;
                    state_reg               <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg          <= 1'b1;
                        m_item_reg.out_tag   <= tag_to_out(res_tag_reg);
                        m_item_reg.out_delay <= time_to_delay(res_delay_reg);
                        m_item_reg.status    <= res_status_reg;
                        m_item_reg.occupancy <= OCC_BITS'(held_reg);
                        state_reg            <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLY(a_held_matches_valid, aclk, aresetn, 1'b1, $countones(valid_reg) == 32'(held_reg), "held count differs from valid slots")
    `ASSERT_IMPLY(a_held_bound, aclk, aresetn, 1'b1, held_reg <= CNT_BITS'(QUEUE_DEPTH), "held count above depth")
    `ASSERT_IMPLY(a_empty_status, aclk, aresetn, m_valid_reg && (m_item_reg.status == STATUS_EMPTY), m_item_reg.occupancy == '0, "empty status with entries held")
    `ASSERT_NEXT(a_commit_frees_one, aclk, aresetn, state_reg == ST_COMMIT, held_reg == $past(held_reg) - CNT_BITS'(1), "remove did not free one slot")

endmodule

@@ tb/tb.sv @@
// testbench of the delay event queue: directed corners, full queue, output stall, random traffic
module tb;
    import deq_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASES       = 16;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    always #4 aclk = ~aclk;

    delay_event_queue u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // predicted queue contents
    logic        slot_used [QUEUE_DEPTH] = '{default: 1'b0};
    tag_t        slot_tag  [QUEUE_DEPTH];
    time_t       slot_time [QUEUE_DEPTH];
    int unsigned slot_age  [QUEUE_DEPTH];
    int unsigned held_count = 0;

    out_item_t   pending_results[$];
    int          error_count  = 0;
    bit          steady       = 1'b0;
    int unsigned hold_request = 0;

    function automatic out_item_t queue_step(input in_item_t it);
        out_item_t res;
        int        free_slot;
        int        best;
        time_t     key_a;
        time_t     key_b;
        time_t     b;
        res = '0;
        case (it.command)
            CMD_INSERT: begin
                free_slot = -1;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (!slot_used[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot < 0) begin
                    res.status = STATUS_FULL;
                end else begin
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                        if (slot_used[i])
                            slot_age[i]++;
                    slot_used[free_slot] = 1'b1;
                    slot_tag[free_slot]  = it.event_tag;
                    slot_time[free_slot] = it.event_delay;
                    slot_age[free_slot]  = 0;
                    held_count++;
                end
            end
            CMD_REMOVE: begin
                best = -1;
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (slot_used[i]) begin
                        if (best < 0) begin
                            best = i;
                        end else begin
                            // offset binary so that an unsigned compare orders signed delays
                            key_a = slot_time[i] ^ TIME_SIGN;
                            key_b = slot_time[best] ^ TIME_SIGN;
                            if (key_a < key_b || (key_a == key_b && slot_age[i] < slot_age[best]))
                                best = i;
                        end
                    end
                end
                if (best < 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.out_tag     = slot_tag[best];
                    res.out_delay   = slot_time[best];
                    slot_used[best] = 1'b0;
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                        if (slot_used[i] && slot_age[i] > slot_age[best])
                            slot_age[i]--;
                    held_count--;
                end
            end
            CMD_TIME: begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (slot_used[i]) begin
                        // saturate at the most negative delay
                        b = slot_time[i] ^ TIME_SIGN;
                        b = (b < it.elapsed) ? '0 : b - it.elapsed;
                        slot_time[i] = b ^ TIME_SIGN;
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = 5'(held_count);
        return res;
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic logic signed [31:0] rand_delay();
        logic signed [31:0] d;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                // a narrow band so that equal delays are common
                d = $urandom_range(8);
                d = d - 4;
            end
            4:       d = {1'b1, 31'($urandom_range(3))};
            5:       d = {1'b0, ~31'($urandom_range(3))};
            default: d = $urandom();
        endcase
        return d;
    endfunction

    function automatic logic [30:0] rand_elapsed();
        logic [30:0] e;
        case ($urandom_range(9))
            0, 1, 2, 3: e = $urandom_range(5);
            4, 5, 6:    e = $urandom_range(100);
            7, 8:       e = 31'($urandom());
            default:    e = 31'h7FFF_FFFF - 31'($urandom_range(3));
        endcase
        return e;
    endfunction

    function automatic in_item_t make_item(input logic [1:0] cmd, input logic [15:0] tag,
                                           input logic signed [31:0] delay,
                                           input logic [30:0] elapsed);
        in_item_t it;
        it.command     = cmd;
        it.event_tag   = tag;
        it.event_delay = delay;
        it.elapsed     = elapsed;
        return it;
    endfunction

    function automatic in_item_t random_item(input int unsigned ins_pct,
                                             input int unsigned rem_pct);
        int unsigned r;
        logic [1:0]  cmd;
        r = $urandom_range(99);
        if (r < ins_pct)
            cmd = CMD_INSERT;
        else if (r < ins_pct + rem_pct)
            cmd = CMD_REMOVE;
        else if (r < 97)
            cmd = CMD_TIME;
        else
            cmd = CMD_UNUSED;
        return make_item(cmd, 16'($urandom()), rand_delay(), rand_elapsed());
    endfunction

    // called at a rising edge; returns at the edge where the item is taken or after its gap
    task automatic send_item(input in_item_t it);
        int unsigned gap;
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(queue_step(it));
        gap = steady ? 0 : idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // returns at once when nothing is outstanding
    task automatic wait_drained();
        if (pending_results.size() != 0) begin
            s_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge aclk);
        end
    endtask

    task automatic test_corner_values();
        send_item(make_item(CMD_REMOVE, 16'hFFFF, -1, 31'h7FFF_FFFF));
        send_item(make_item(CMD_INSERT, 16'hFFFF, 32'sh7FFF_FFFF, 31'h0));
        send_item(make_item(CMD_INSERT, 16'h0000, 32'sh8000_0000, 31'h7FFF_FFFF));
        send_item(make_item(CMD_INSERT, 16'h1234, 0, 31'h0));
        // equal delays: the newer one must leave first
        send_item(make_item(CMD_INSERT, 16'h5678, 0, 31'h0));
        send_item(make_item(CMD_TIME, 16'h0000, 0, 31'h0));
        send_item(make_item(CMD_UNUSED, 16'hFFFF, -1, 31'h7FFF_FFFF));
        send_item(make_item(CMD_REMOVE, 16'h0000, 0, 31'h0));
        send_item(make_item(CMD_REMOVE, 16'h0000, 0, 31'h0));
        send_item(make_item(CMD_TIME, 16'h0000, 0, 31'h7FFF_FFFF));
        send_item(make_item(CMD_INSERT, 16'hAAAA, 32'sh8000_0000, 31'h0));
        // the minimum must stay put
        send_item(make_item(CMD_TIME, 16'h0000, 0, 31'h1));
        repeat (4) send_item(make_item(CMD_REMOVE, 16'h5555, 0, 31'h0));
        wait_drained();
    endtask

    task automatic test_full_queue();
        steady = 1'b1;
        repeat (QUEUE_DEPTH)
            send_item(make_item(CMD_INSERT, 16'($urandom()), rand_delay(), rand_elapsed()));
        steady = 1'b0;
        repeat (2)
            send_item(make_item(CMD_INSERT, 16'($urandom()), rand_delay(), rand_elapsed()));
        send_item(make_item(CMD_TIME, 16'($urandom()), rand_delay(), rand_elapsed()));
        repeat (QUEUE_DEPTH + 1)
            send_item(make_item(CMD_REMOVE, 16'($urandom()), rand_delay(), rand_elapsed()));
        wait_drained();
    endtask

    task automatic test_output_stall();
        // the sink holds off while items keep coming, so the input must stall
        hold_request = HOLD_CYCLES;
        steady = 1'b1;
        repeat (20) send_item(random_item(40, 40));
        steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned ins_pct;
        int unsigned rem_pct;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 3)
                0:       begin ins_pct = 60; rem_pct = 25; end
                1:       begin ins_pct = 25; rem_pct = 60; end
                default: begin ins_pct = 40; rem_pct = 40; end
            endcase
            steady = (phase % 5 == 3);
            repeat (PHASE_ITEMS) send_item(random_item(ins_pct, rem_pct));
            if (phase % 4 == 3)
                wait_drained();
        end
        steady = 1'b0;
        wait_drained();
    endtask

    // result sink with random back-pressure
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (hold_request > 0) begin
                stall_left   = hold_request - 1;
                hold_request = 0;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                stall_left = idle_gap();
                m_ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    function automatic void check_field(input string name, input longint want_v,
                                        input longint got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_item);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_tag", want.out_tag, m_item.out_tag);
                check_field("out_delay", want.out_delay, m_item.out_delay);
                check_field("status", want.status, m_item.status);
                check_field("occupancy", want.occupancy, m_item.occupancy);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_corner_values();
        test_full_queue();
        test_output_stall();
        test_random_traffic();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ delay_event_queue.f @@
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/deq_alu.sv
hw/rtl/delay_event_queue.sv
tb/tb.sv
